FILE: design/dtp_pkg.sv
// Package for the decimal triple parser: widths, beat types, character and error codes.
// Also holds the decimal scale table and the reciprocal constants for the fraction.
// No dependencies.
`timescale 1ns / 1ps

package dtp_pkg;

    localparam int INT_BITS    = 24;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_DIGITS = 6;

    localparam int VALUE_W = 40;

    localparam longint POW_D      = 64'd10 ** FRAC_DIGITS;
    localparam int     FRAC_W     = $clog2(POW_D);
    localparam int     FRAC_CNT_W = $clog2(FRAC_DIGITS + 1);

    // The scaled fraction f * 2^FRAC_BITS / 10^FRAC_DIGITS equals
    // f * 2^FRAC_SHIFT / 5^FRAC_DIGITS. The divisor is odd, so rounding half up
    // becomes a bias of (5^FRAC_DIGITS - 1) / 2 ahead of a floor division,
    // which is done by a multiply with a rounded-up reciprocal.
    localparam longint FIVE_POW    = 64'd5 ** FRAC_DIGITS;
    localparam int     FRAC_SHIFT  = FRAC_BITS - FRAC_DIGITS;
    localparam int     RND_W       = FRAC_W + FRAC_SHIFT + 1;
    localparam int     RECIP_SHIFT = RND_W + $clog2(FIVE_POW);
    localparam int     RECIP_W     = RND_W + 1;
    localparam int     PROD_W      = RND_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + FIVE_POW - 64'd1) / FIVE_POW);
    localparam logic [RND_W-1:0]   RND_BIAS  = RND_W'((FIVE_POW - 64'd1) / 64'd2);

    localparam int MAG_W  = INT_BITS + FRAC_BITS + 1;
    localparam int CALC_W = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;

    localparam logic [MAG_W-1:0] MAG_HALF = {2'b01, {(INT_BITS + FRAC_BITS - 1){1'b0}}};

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FEW   = 2'd1;
    localparam logic [1:0] ERR_CHAR  = 2'd2;
    localparam logic [1:0] ERR_EXTRA = 2'd3;

    typedef logic [FRAC_W-1:0]     t_frac;
    typedef logic [FRAC_CNT_W-1:0] t_fcnt;
    typedef logic [FRAC_BITS:0]    t_fr;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_req;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                index;
        logic                      last;
        logic [1:0]                error;
    } t_out_beat;

    typedef struct packed {
        logic                zero_val;
        logic                negative;
        logic [INT_BITS-1:0] int_acc;
        logic [1:0]          index;
        logic                last;
        logic [1:0]          error;
    } t_side;

    typedef logic [FRAC_DIGITS:0][FRAC_W-1:0] t_scale_tab;

    function automatic t_scale_tab build_scale_tab();
        t_scale_tab tab;
        longint     p;
        p = 1;
        for (int k = FRAC_DIGITS; k >= 0; k--) begin
            tab[k] = FRAC_W'(p);
            p = p * 10;
        end
        return tab;
    endfunction

    localparam t_scale_tab SCALE_TAB = build_scale_tab();

endpackage

FILE: design/dtp_fsm.sv
// Character parser of the decimal triple parser: phase, number state and accumulators.
// Registers each produced result, with the raw number fields, for the value pipeline.
// Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_fsm import dtp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_accept,
    input  t_in_beat i_beat,
    input  logic     i_mode,
    output logic     o_valid,
    output t_side    o_side,
    output t_frac    o_frac_acc,
    output t_fcnt    o_frac_cnt
);

    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_SIGN  = 3'd2;
    localparam logic [2:0] PH_INT   = 3'd3;
    localparam logic [2:0] PH_DOT   = 3'd4;
    localparam logic [2:0] PH_FRAC  = 3'd5;
    localparam logic [2:0] PH_SEP   = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    typedef struct packed {
        logic                negative;
        logic [INT_BITS-1:0] int_acc;
        t_frac               frac_acc;
        t_fcnt               frac_cnt;
        logic                stopped;
    } t_num;

    typedef struct packed {
        logic [2:0] phase;
        t_num       num;
    } t_feed;

    localparam t_num NUM_CLEAR = '0;

    logic [2:0] r_phase, n_phase;
    logic [1:0] r_num_idx, n_num_idx;
    t_num       r_num, n_num;
    logic       r_s0_valid;
    t_side      r_s0_side;
    t_frac      r_s0_frac;
    t_fcnt      r_s0_cnt;

    logic [2:0] cur_phase;
    logic [1:0] cur_idx;
    t_num       cur_num;
    t_feed      fed_start, fed_cont;
    logic       emit, zero_val, e_last;
    logic [1:0] e_idx, e_err;
    logic [7:0] c;

    function automatic logic is_digit(logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_space(logic [7:0] ch);
        return ch inside {[CH_TAB:CH_CR], CH_SPACE};
    endfunction

    function automatic logic is_end(logic [7:0] ch);
        return (ch == CH_NUL) || is_space(ch);
    endfunction

    function automatic logic is_tok(logic [7:0] ch, logic mode);
        return is_digit(ch) || (!mode && ((ch == CH_MINUS) || (ch == CH_DOT)));
    endfunction

    function automatic t_feed feed_token(logic [2:0] ph, t_num num, logic [7:0] ch);
        t_feed                 r;
        logic [INT_BITS+3:0]   iext;
        logic [FRAC_W+3:0]     fext;
        r.phase = ph;
        r.num   = num;
        iext    = {4'b0, num.int_acc};
        fext    = {4'b0, num.frac_acc};
        if (!num.stopped) begin
            if (is_digit(ch)) begin
                if ((ph == PH_DOT) || (ph == PH_FRAC)) begin
                    if (num.frac_cnt < FRAC_CNT_W'(FRAC_DIGITS)) begin
                        fext = (fext << 3) + (fext << 1) + (FRAC_W + 4)'(ch[3:0]);
                        r.num.frac_acc = fext[FRAC_W-1:0];
                        r.num.frac_cnt = num.frac_cnt + 1'b1;
                    end
                    r.phase = PH_FRAC;
                end else begin
                    iext = (iext << 3) + (iext << 1) + (INT_BITS + 4)'(ch[3:0]);
                    if (iext[INT_BITS+3:INT_BITS] != 4'd0) begin
                        r.num.int_acc = '1;
                    end else begin
                        r.num.int_acc = iext[INT_BITS-1:0];
                    end
                    r.phase = PH_INT;
                end
            end else if (ch == CH_MINUS) begin
                if (ph == PH_START) begin
                    r.num.negative = 1'b1;
                    r.phase        = PH_SIGN;
                end else begin
                    if (ph == PH_SIGN) begin
                        r.num.negative = 1'b0;
                    end
                    r.num.stopped = 1'b1;
                end
            end else begin
                if ((ph == PH_START) || (ph == PH_SIGN) || (ph == PH_INT)) begin
                    r.phase = PH_DOT;
                end else begin
                    r.num.stopped = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        c         = i_beat.text_byte;
        cur_phase = i_beat.start_req ? PH_SKIP : r_phase;
        cur_idx   = i_beat.start_req ? 2'd0 : r_num_idx;
        cur_num   = i_beat.start_req ? NUM_CLEAR : r_num;
        fed_start = feed_token(PH_START, NUM_CLEAR, c);
        fed_cont  = feed_token(cur_phase, cur_num, c);
        n_phase   = cur_phase;
        n_num_idx = cur_idx;
        n_num     = cur_num;
        emit      = 1'b0;
        zero_val  = 1'b0;
        e_idx     = cur_idx;
        e_last    = 1'b0;
        e_err     = ERR_NONE;
        case (cur_phase)
            PH_DONE: begin
            end
            PH_SKIP: begin
                if (is_space(c) || (i_mode && (c == CH_COMMA))) begin
                end else if (c == CH_NUL) begin
                    emit     = 1'b1;
                    zero_val = 1'b1;
                    e_idx    = 2'd0;
                    e_last   = 1'b1;
                    e_err    = ERR_FEW;
                end else if (is_tok(c, i_mode)) begin
                    n_phase = fed_start.phase;
                    n_num   = fed_start.num;
                end else begin
                    emit     = 1'b1;
                    zero_val = 1'b1;
                    e_idx    = 2'd0;
                    e_last   = 1'b1;
                    e_err    = ERR_CHAR;
                end
            end
            PH_SEP: begin
                if (cur_idx == 2'd3) begin
                    emit   = 1'b1;
                    e_idx  = 2'd2;
                    e_last = 1'b1;
                    e_err  = is_tok(c, i_mode) ? ERR_EXTRA : ERR_NONE;
                end else if (is_tok(c, i_mode)) begin
                    n_phase = fed_start.phase;
                    n_num   = fed_start.num;
                end else begin
                    emit     = 1'b1;
                    zero_val = 1'b1;
                    e_last   = 1'b1;
                    e_err    = is_end(c) ? ERR_FEW : ERR_CHAR;
                end
            end
            default: begin
                if (is_tok(c, i_mode)) begin
                    n_phase = fed_cont.phase;
                    n_num   = fed_cont.num;
                end else if (is_end(c)) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    e_err  = (cur_idx == 2'd2) ? ERR_NONE : ERR_FEW;
                end else if (i_mode && (c != CH_COMMA)) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    e_err  = (cur_idx == 2'd2) ? ERR_NONE : ERR_CHAR;
                end else begin
                    n_num_idx = cur_idx + 2'd1;
                    n_phase   = PH_SEP;
                    emit      = (cur_idx != 2'd2);
                end
            end
        endcase
        if (emit && e_last) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SKIP;
            r_num_idx  <= 2'd0;
            r_num      <= NUM_CLEAR;
            r_s0_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase   <= n_phase;
                r_num_idx <= n_num_idx;
                r_num     <= n_num;
            end
            if (i_en) begin
                r_s0_valid <= i_accept && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_side.zero_val <= zero_val;
            r_s0_side.negative <= cur_num.negative;
            r_s0_side.int_acc  <= cur_num.int_acc;
            r_s0_side.index    <= e_idx;
            r_s0_side.last     <= e_last;
            r_s0_side.error    <= e_err;
            r_s0_frac          <= cur_num.frac_acc;
            r_s0_cnt           <= cur_num.frac_cnt;
        end
    end

    assign o_valid    = r_s0_valid;
    assign o_side     = r_s0_side;
    assign o_frac_acc = r_s0_frac;
    assign o_frac_cnt = r_s0_cnt;

endmodule

FILE: design/dtp_div_stage.sv
// One registered stage that turns the normalized decimal fraction into rounded binary
// fraction bits by a reciprocal multiply, with the side fields carried along.
// Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_div_stage import dtp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_frac i_frac,
    output logic  o_valid,
    output t_side o_side,
    output t_fr   o_fr
);

    logic              r_valid;
    t_side             r_side;
    t_fr               r_fr, n_fr;
    logic [RND_W-1:0]  num;
    logic [PROD_W-1:0] prod;

    always_comb begin
        num  = (RND_W'(i_frac) << FRAC_SHIFT) + RND_BIAS;
        prod = {{RECIP_W{1'b0}}, num} * {{RND_W{1'b0}}, RECIP_MUL};
        n_fr = prod[RECIP_SHIFT +: FRAC_BITS + 1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_fr   <= n_fr;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_fr    = r_fr;

endmodule

FILE: design/dtp_value_pipe.sv
// Value pipeline: fraction normalization multiply, reciprocal divide stage, and the final
// fixed-point assembly with saturation, sign and mode selection into the output register.
// Depends on dtp_pkg and dtp_div_stage.
`timescale 1ns / 1ps

module dtp_value_pipe import dtp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_mode,
    input  logic      i_valid,
    input  t_side     i_side,
    input  t_frac     i_frac_acc,
    input  t_fcnt     i_frac_cnt,
    output logic      o_valid,
    output t_out_beat o_beat
);

    logic      r_s1_valid;
    t_side     r_s1_side;
    t_frac     r_s1_frac;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    logic [2*FRAC_W-1:0] prod;

    logic  d_valid;
    t_side d_side;
    t_fr   d_fr;

    logic [MAG_W-1:0]  mag_raw, mag, pos;
    logic [CALC_W-1:0] val;
    t_side             fs;

    assign prod = {{FRAC_W{1'b0}}, i_frac_acc} * {{FRAC_W{1'b0}}, SCALE_TAB[i_frac_cnt]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_side <= i_side;
            r_s1_frac <= prod[FRAC_W-1:0];
        end
    end

    dtp_div_stage u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_s1_valid),
        .i_side  (r_s1_side),
        .i_frac  (r_s1_frac),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_fr    (d_fr)
    );

    always_comb begin
        fs      = d_side;
        mag_raw = {1'b0, fs.int_acc, {FRAC_BITS{1'b0}}} + MAG_W'(d_fr);
        if (fs.int_acc[INT_BITS-1] || (mag_raw > MAG_HALF)) begin
            mag = MAG_HALF;
        end else begin
            mag = mag_raw;
        end
        pos = (mag == MAG_HALF) ? (MAG_HALF - MAG_W'(1)) : mag;
        if (fs.zero_val) begin
            val = '0;
        end else if (i_mode) begin
            val = CALC_W'(fs.int_acc);
        end else if (fs.negative) begin
            val = CALC_W'(0) - CALC_W'(mag);
        end else begin
            val = CALC_W'(pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_beat.value <= val[VALUE_W-1:0];
            r_out_beat.index <= fs.index;
            r_out_beat.last  <= fs.last;
            r_out_beat.error <= fs.error;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out_beat;

endmodule

FILE: design/decimal_triple_parser_unit.sv
// Top level of the decimal triple parser: handshakes, mode register, parser and value pipeline.
// Depends on dtp_pkg, dtp_fsm and dtp_value_pipe.
//
//   Channel   Direction   Handshake                 Beat
//   in        input       i_in_valid / o_in_ready   t_in_beat  (text_byte, start_req)
//   out       output      o_out_valid / i_out_ready t_out_beat (value, index, last, error)
//   cfg       input       i_cfg_we                  i_cfg_data (mode)
//
// One byte is taken per cycle while the output is not stalled; its result passes through
// the four register stages: parser, fraction scaling, reciprocal divide
// and output.
// All pipeline stages advance together; when the output register holds a beat that is
// not taken, the whole pipeline and the input stall.
// Reset is synchronous and clears the parser state, the valid bits and the mode.
`timescale 1ns / 1ps

module decimal_triple_parser_unit import dtp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    logic  r_mode;
    logic  en, accept;
    logic  s0_valid;
    t_side s0_side;
    t_frac s0_frac;
    t_fcnt s0_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    assign en         = !o_out_valid || i_out_ready;
    assign accept     = i_in_valid && en;
    assign o_in_ready = en;

    dtp_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_accept   (accept),
        .i_beat     (i_in_data),
        .i_mode     (r_mode),
        .o_valid    (s0_valid),
        .o_side     (s0_side),
        .o_frac_acc (s0_frac),
        .o_frac_cnt (s0_cnt)
    );

    dtp_value_pipe u_value (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_mode     (r_mode),
        .i_valid    (s0_valid),
        .i_side     (s0_side),
        .i_frac_acc (s0_frac),
        .i_frac_cnt (s0_cnt),
        .o_valid    (o_out_valid),
        .o_beat     (o_out_data)
    );

    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> (o_out_data.error == ERR_NONE))
        else $error("non-final beat carries an error code");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.index != 2'd3))
        else $error("result index out of range");

    a_extra_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.error == ERR_EXTRA)) |->
            ((o_out_data.index == 2'd2) && o_out_data.last))
        else $error("extra-number error without a held third value");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_valid && !en) |=> s0_valid)
        else $error("parser result lost during output stall");

endmodule

FILE: sim/tb_decimal_triple_parser_unit.sv
// Self-checking testbench for decimal_triple_parser_unit: directed strings, then random
// triples, some malformed, with noise, in both number modes, with random stalls on both sides.
// Depends on dtp_pkg and the parser RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb_decimal_triple_parser_unit;
    import dtp_pkg::*;

    localparam int HOLD_CYCLES   = 90;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int MAX_PRINTS    = 200;

    localparam logic [31:0] INT_LIMIT = (32'd1 << INT_BITS) - 32'd1;

    typedef enum logic [2:0] {
        ST_SKIP,
        ST_START,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_SEP,
        ST_DONE
    } t_stage;

    class triple_book;
        bit          color;
        t_stage      stage;
        logic [1:0]  done_count;
        bit          neg;
        logic [31:0] whole;
        logic [19:0] frac;
        int          frac_n;
        bit          stopped;
        t_out_beat   pending[$];
        int          errors;

        function new();
            color  = 1'b0;
            errors = 0;
            restart();
        endfunction

        static function bit is_blank(logic [7:0] c);
            return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
        endfunction

        static function bit is_end(logic [7:0] c);
            return c == CH_NUL || is_blank(c);
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        static function bit token_char(logic [7:0] c, bit col);
            return is_digit(c) || (!col && (c == CH_MINUS || c == CH_DOT));
        endfunction

        function void clear_number();
            neg     = 1'b0;
            whole   = '0;
            frac    = '0;
            frac_n  = 0;
            stopped = 1'b0;
        endfunction

        function void restart();
            stage      = ST_SKIP;
            done_count = 2'd0;
            clear_number();
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // Q(INT_BITS).(FRAC_BITS) value, kept fraction digits rounded half up; whole if color.
        function logic [VALUE_W-1:0] fixed_value();
            logic [63:0] scale;
            logic [63:0] frac_q;
            logic [63:0] mag;
            logic [63:0] half;
            if (color) begin
                return VALUE_W'(whole);
            end
            scale = 64'd1;
            for (int k = 0; k < frac_n; k++) begin
                scale = scale * 64'd10;
            end
            frac_q = '0;
            if (frac_n != 0) begin
                frac_q = ((64'(frac) << FRAC_BITS) + scale / 64'd2) / scale;
            end
            half = 64'd1 << (INT_BITS + FRAC_BITS - 1);
            if (64'(whole) >= (64'd1 << (INT_BITS - 1))) begin
                mag = half;
            end else begin
                mag = (64'(whole) << FRAC_BITS) + frac_q;
            end
            if (mag > half) begin
                mag = half;
            end
            if (neg) begin
                return VALUE_W'(64'd0 - mag);
            end
            return VALUE_W'((mag == half) ? half - 64'd1 : mag);
        endfunction

        function void expect_beat(logic [VALUE_W-1:0] v, logic [1:0] idx, logic last,
                                  logic [1:0] err);
            t_out_beat w;
            w.value = v;
            w.index = idx;
            w.last  = last;
            w.error = err;
            pending.push_back(w);
            if (last) begin
                stage = ST_DONE;
            end
        endfunction

        function void feed(logic [7:0] c);
            if (stopped) begin
                return;
            end
            if (is_digit(c)) begin
                if (stage == ST_DOT || stage == ST_FRAC) begin
                    if (frac_n < FRAC_DIGITS) begin
                        frac   = frac * 20'd10 + 20'(c - CH_ZERO);
                        frac_n = frac_n + 1;
                    end
                    stage = ST_FRAC;
                end else begin
                    whole = whole * 32'd10 + 32'(c - CH_ZERO);
                    if (whole > INT_LIMIT) begin
                        whole = INT_LIMIT;
                    end
                    stage = ST_INT;
                end
            end else if (c == CH_MINUS) begin
                if (stage == ST_START) begin
                    neg   = 1'b1;
                    stage = ST_SIGN;
                end else begin
                    if (stage == ST_SIGN) begin
                        neg = 1'b0;
                    end
                    stopped = 1'b1;
                end
            end else begin
                if (stage == ST_START || stage == ST_SIGN || stage == ST_INT) begin
                    stage = ST_DOT;
                end else begin
                    stopped = 1'b1;
                end
            end
        endfunction

        function void begin_token(logic [7:0] c);
            clear_number();
            stage = ST_START;
            feed(c);
        endfunction

        function void close_token(logic [7:0] c);
            logic [1:0]         idx;
            logic [VALUE_W-1:0] v;
            idx = done_count;
            v   = fixed_value();
            if (is_end(c)) begin
                expect_beat(v, idx, 1'b1, (idx == 2'd2) ? ERR_NONE : ERR_FEW);
            end else if (color && c != CH_COMMA) begin
                expect_beat(v, idx, 1'b1, (idx == 2'd2) ? ERR_NONE : ERR_CHAR);
            end else begin
                done_count = idx + 2'd1;
                stage      = ST_SEP;
                if (idx < 2'd2) begin
                    expect_beat(v, idx, 1'b0, ERR_NONE);
                end
            end
        endfunction

        function void note_input(t_in_beat b);
            logic [7:0] c;
            c = b.text_byte;
            if (b.start_req) begin
                restart();
            end
            case (stage)
                ST_DONE: begin
                end
                ST_SKIP: begin
                    if (!(is_blank(c) || (color && c == CH_COMMA))) begin
                        if (c == CH_NUL) begin
                            expect_beat('0, 2'd0, 1'b1, ERR_FEW);
                        end else if (token_char(c, color)) begin
                            begin_token(c);
                        end else begin
                            expect_beat('0, 2'd0, 1'b1, ERR_CHAR);
                        end
                    end
                end
                ST_SEP: begin
                    if (done_count == 2'd3) begin
                        expect_beat(fixed_value(), 2'd2, 1'b1,
                                    token_char(c, color) ? ERR_EXTRA : ERR_NONE);
                    end else if (token_char(c, color)) begin
                        begin_token(c);
                    end else begin
                        expect_beat('0, done_count, 1'b1, is_end(c) ? ERR_FEW : ERR_CHAR);
                    end
                end
                default: begin
                    if (token_char(c, color)) begin
                        feed(c);
                    end else begin
                        close_token(c);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("mismatch at %0t ns: %s", $time, msg);
            end
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat value=%0d index=%0d last=%0d error=%0d",
                                 $signed(got.value), got.index, got.last, got.error));
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value) begin
                report($sformatf("value %0d, expected %0d", $signed(got.value),
                                 $signed(want.value)));
            end
            if (got.index !== want.index) begin
                report($sformatf("index %0d, expected %0d", got.index, want.index));
            end
            if (got.last !== want.last) begin
                report($sformatf("last %0d, expected %0d", got.last, want.last));
            end
            if (got.error !== want.error) begin
                report($sformatf("error %0d, expected %0d", got.error, want.error));
            end
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;

    bit         tx_calm   = 1'b0;
    bit         rx_calm   = 1'b0;
    bit         hold_long = 1'b0;
    int         sent      = 0;
    logic [7:0] text_q[$];

    triple_book book = new();

    decimal_triple_parser_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic int draw_gap(input bit calm);
        if (calm) begin
            return 0;
        end
        if ($urandom_range(0, 3) == 0) begin
            return int'($urandom_range(0, 16));
        end
        return int'($urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_space();
        if ($urandom_range(0, 2) == 0) begin
            return CH_SPACE;
        end
        return CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] pick_end();
        if ($urandom_range(0, 3) == 0) begin
            return CH_NUL;
        end
        return pick_space();
    endfunction

    function automatic logic [7:0] pick_other(input bit col);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (triple_book::token_char(c, col) || triple_book::is_end(c) ||
               (col && c == CH_COMMA)) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_sep(input bit col);
        if (col || $urandom_range(0, 2) != 0) begin
            return CH_COMMA;
        end
        return pick_other(1'b0);
    endfunction

    function automatic logic [7:0] pick_token_char(input bit col);
        if (!col && $urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? CH_MINUS : CH_DOT;
        end
        return pick_digit();
    endfunction

    function automatic int draw_int_len(input bit col);
        case ($urandom_range(0, 11))
            0: return col ? 1 : 0;
            1: return int'($urandom_range(7, 10));
            default: return int'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic void add_point_token();
        int base;
        int n_frac;
        base = text_q.size();
        if ($urandom_range(0, 2) == 0) text_q.push_back(CH_MINUS);
        if ($urandom_range(0, 15) == 0) text_q.push_back(CH_MINUS);
        repeat (draw_int_len(1'b0)) text_q.push_back(pick_digit());
        if ($urandom_range(0, 1) == 0) begin
            text_q.push_back(CH_DOT);
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(6, 8)) text_q.push_back(CH_NINE);
            end else begin
                n_frac = int'($urandom_range(0, 8));
                repeat (n_frac) begin
                    case ($urandom_range(0, 3))
                        0: text_q.push_back(CH_ZERO);
                        1: text_q.push_back(CH_NINE);
                        default: text_q.push_back(pick_digit());
                    endcase
                end
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            text_q.push_back(pick_token_char(1'b0));
            repeat ($urandom_range(0, 2)) text_q.push_back(pick_token_char(1'b0));
        end
        if (text_q.size() == base) text_q.push_back(pick_digit());
    endfunction

    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        book.note_input(b);
    endtask

    task automatic send_text(input string s, input bit restart);
        t_in_beat b;
        for (int k = 0; k < s.len(); k++) begin
            b.text_byte = s[k];
            b.start_req = restart && (k == 0);
            send_beat(b);
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input bit restart);
        t_in_beat b;
        b.text_byte = c;
        b.start_req = restart;
        send_beat(b);
    endtask

    task automatic send_noise();
        t_in_beat b;
        repeat ($urandom_range(1, 6)) begin
            b.text_byte = 8'($urandom_range(0, 255));
            b.start_req = ($urandom_range(0, 3) == 0);
            send_beat(b);
            sent++;
        end
    endtask

    task automatic send_random_triple(input bit col);
        int       n_tok;
        t_in_beat b;
        text_q.delete();
        repeat ($urandom_range(0, 2)) begin
            text_q.push_back((col && $urandom_range(0, 1)) ? CH_COMMA : pick_space());
        end
        n_tok = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) : 3;
        for (int k = 0; k < n_tok; k++) begin
            if (col) begin
                repeat (draw_int_len(1'b1)) text_q.push_back(pick_digit());
            end else begin
                add_point_token();
            end
            if (k < n_tok - 1) text_q.push_back(pick_sep(col));
        end
        if (n_tok == 0) begin
            text_q.push_back($urandom_range(0, 1) ? CH_NUL : pick_other(col));
        end else begin
            case ($urandom_range(0, 5))
                0, 5: text_q.push_back(pick_end());
                1: begin
                    text_q.push_back(pick_sep(col));
                    text_q.push_back(pick_end());
                end
                2: begin
                    text_q.push_back(pick_sep(col));
                    text_q.push_back(pick_other(col));
                end
                3: begin
                    text_q.push_back(pick_sep(col));
                    text_q.push_back(pick_token_char(col));
                end
                default: text_q.push_back(pick_other(col));
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        foreach (text_q[k]) begin
            b.text_byte = text_q[k];
            b.start_req = (k == 0) ? ($urandom_range(0, 31) != 0) : ($urandom_range(0, 63) == 0);
            send_beat(b);
            sent++;
        end
    endtask

    task automatic wait_drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (book.outstanding() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we     <= 1'b0;
        book.color = m;
    endtask

    initial begin
        forever begin
            int gap;
            while (!rst_n) @(posedge clk);
            gap = draw_gap(rx_calm);
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
            end else if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            book.check_result(out_data);
        end
    end

    initial begin
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        send_text("\t-.5,.-,1x", 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_text("-9999999,", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NUL, 1'b1);
        wait_drain();
        write_mode(1'b1);
        send_text(",7;", 1'b1);

        for (int p = 0; p < 4; p++) begin
            wait_drain();
            write_mode(p[0] ? 1'b0 : 1'b1);
            if (p == 2) begin
                hold_long = 1'b1;
                tx_calm   = 1'b1;
            end
            target = sent + RANDOM_ITEMS / 4;
            while (sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    send_random_triple(book.color);
                end
                if (!hold_long && $urandom_range(0, 7) == 0) tx_calm = !tx_calm;
                if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
            end
        end

        wait_drain();
        if (book.outstanding() != 0) begin
            book.report($sformatf("%0d expected beats never arrived", book.outstanding()));
        end
        if (book.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/dtp_pkg.sv
design/dtp_fsm.sv
design/dtp_div_stage.sv
design/dtp_value_pipe.sv
design/decimal_triple_parser_unit.sv
sim/tb_decimal_triple_parser_unit.sv
